@@ rtl/ychc_pkg.sv @@
// ----------------------------------------------------------------------------
// ychc_pkg
// shared types and constants of the ycbcr to hsv color classifier
// ----------------------------------------------------------------------------
package ychc_pkg;

  // default number of fraction bits of hue, saturation and value
  localparam int HSV_FRACTION_BITS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH = 3'd5;

  localparam logic [8:0] HUE_LOW_RST  = 9'd190;
  localparam logic [8:0] HUE_HIGH_RST = 9'd250;
  localparam logic [6:0] SAT_LOW_RST  = 7'd39;
  localparam logic [6:0] SAT_HIGH_RST = 7'd100;
  localparam logic [6:0] VAL_LOW_RST  = 7'd32;
  localparam logic [6:0] VAL_HIGH_RST = 7'd100;

  // color conversion coefficients, 16 fraction bits
  localparam logic signed [18:0] K_Y   = 19'sd76309;
  localparam logic signed [18:0] K_RCR = 19'sd104597;
  localparam logic signed [18:0] K_GCB = 19'sd25664;
  localparam logic signed [18:0] K_GCR = 19'sd53268;
  localparam logic signed [18:0] K_BCB = 19'sd132201;
  localparam logic signed [29:0] HALF16 = 30'sd32768;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
  } pix_in_t;

  typedef struct packed {
    logic        in_range;
    logic [12:0] hue;
    logic [10:0] saturation;
    logic [10:0] brightness;
  } pix_out_t;

endpackage

@@ rtl/ycbcr_hsv_color_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// ycbcr_hsv_color_classifier_unit
// studio-range ycbcr pixel to hsv with a configurable color window test
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o carry one pixel (Y, Cb, Cr) per
//   transaction. output channel: out_valid_o / out_ready_i carry hue,
//   saturation, value and the in_range flag, one transaction per pixel.
//   configuration: cfg_we_i with cfg_index_i / cfg_data_i writes one bound
//   register per cycle; write only while no pixel is in flight.
//   throughput: one pixel per clock while the skid register is empty.
//   path from input transaction to output valid: input register, four
//   compute stages, 7 + HsvFractionBits stages of the two restoring
//   dividers (hue, saturation, one quotient bit per stage) and the output
//   register; value divides by 255 through a reciprocal multiply delayed
//   to line up with the dividers.
//   stall: the whole pipeline advances on a single enable; a result that is
//   not taken drops into a skid register, and the pipeline holds only while
//   that skid register is full, so nothing is lost or repeated.
//   reset: clears all valid bits and the skid register and loads the default
//   bounds; there is no clearing pass.
// ----------------------------------------------------------------------------
module ycbcr_hsv_color_classifier_unit #(
  parameter int HsvFractionBits = ychc_pkg::HSV_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ychc_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ychc_pkg::pix_out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ychc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ychc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ychc_pkg::*;

  localparam int F   = HsvFractionBits;
  localparam int NW  = 15 + F;          // numerator width of every divider
  localparam int QW  = 7 + F;           // quotient width, holds up to 120 * 2^F
  localparam int HW  = 9 + F;           // full hue width, below 512 * 2^F
  localparam int HueMaxI  = 360 * (1 << F) - 1;
  localparam int HueFullI = 360 * (1 << F);
  // value / 255 as a reciprocal multiply, exact for every NW-bit numerator
  localparam int     VShift = NW + 8;
  localparam longint VRecip = ((longint'(1) << VShift) + 254) / 255;
  localparam int     PW     = 2 * NW + 1;

  // bound registers
  logic [8:0] hue_low_q, hue_high_q;
  logic [6:0] sat_low_q, sat_high_q, val_low_q, val_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HUE_LOW_RST;
      hue_high_q <= HUE_HIGH_RST;
      sat_low_q  <= SAT_LOW_RST;
      sat_high_q <= SAT_HIGH_RST;
      val_low_q  <= VAL_LOW_RST;
      val_high_q <= VAL_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HUE_LOW:  hue_low_q  <= cfg_data_i;
        CFG_HUE_HIGH: hue_high_q <= cfg_data_i;
        CFG_SAT_LOW:  sat_low_q  <= cfg_data_i[6:0];
        CFG_SAT_HIGH: sat_high_q <= cfg_data_i[6:0];
        CFG_VAL_LOW:  val_low_q  <= cfg_data_i[6:0];
        CFG_VAL_HIGH: val_high_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // single pipeline enable: hold only while the skid register is full
  logic skid_vld_q;
  logic en;
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // stage 0: input register
  logic    vld0_q;
  pix_in_t pix0_q;

  // stage 1: coefficient products
  logic              vld1_q;
  logic signed [27:0] ty_q, tr_q, tgb_q, tgr_q, tb_q;
  logic signed [8:0]  y_s, cb_s, cr_s;

  assign y_s  = $signed({1'b0, pix0_q.luma}) - 9'sd16;
  assign cb_s = $signed({1'b0, pix0_q.blue_diff}) - 9'sd128;
  assign cr_s = $signed({1'b0, pix0_q.red_diff}) - 9'sd128;

  // stage 2: rounded and clamped rgb
  logic       vld2_q;
  logic [7:0] r_q, g_q, b_q;
  logic signed [29:0] acc_r, acc_g, acc_b;

  assign acc_r = 30'(ty_q) + 30'(tr_q) + HALF16;
  assign acc_g = 30'(ty_q) - 30'(tgb_q) - 30'(tgr_q) + HALF16;
  assign acc_b = 30'(ty_q) + 30'(tb_q) + HALF16;

  function automatic logic [7:0] clamp8(logic signed [29:0] acc);
    logic [7:0] res;
    if (acc < 0) res = 8'd0;
    else if (acc[29:24] != '0) res = 8'd255;
    else res = acc[23:16];
    return res;
  endfunction

  // stage 3: max, delta and hue sector
  logic       vld3_q;
  logic [7:0] mx_q, d3_q;
  logic [8:0] n3_q, base3_q;
  logic       gray3_q;
  logic [7:0] mx_c, mn_c, d_c;
  logic [8:0] n_c, base_c;

  always_comb begin
    mx_c = r_q;
    mn_c = r_q;
    if (g_q > mx_c) mx_c = g_q;
    if (b_q > mx_c) mx_c = b_q;
    if (g_q < mn_c) mn_c = g_q;
    if (b_q < mn_c) mn_c = b_q;
    d_c = mx_c - mn_c;
    // hue = base * 2^F + floor(60 * 2^F * n / d), n in 0 .. 2d
    if (r_q == mx_c) begin
      if (g_q >= b_q) begin
        base_c = 9'd0;
        n_c    = 9'(g_q) - 9'(b_q);
      end else begin
        base_c = 9'd300;
        n_c    = 9'(d_c) + 9'(g_q) - 9'(b_q);
      end
    end else if (g_q == mx_c) begin
      base_c = 9'd60;
      n_c    = 9'(d_c) + 9'(b_q) - 9'(r_q);
    end else begin
      base_c = 9'd180;
      n_c    = 9'(d_c) + 9'(r_q) - 9'(g_q);
    end
  end

  // stage 4: divider numerators
  logic          vld4_q;
  logic [NW-1:0] hnum_q, snum_q, vnum_q;
  logic [7:0]    d4_q;
  logic [7:0]    mx4_q;   // saturation divides by max
  logic [8:0]    base4_q;
  logic          gray4_q;

  // divider stages, side data carried alongside
  logic       dvld_q  [QW];
  logic [8:0] dbase_q [QW];
  logic       dgray_q [QW];
  logic [QW-1:0] dval_q [QW];
  logic [QW-1:0] q_hue, q_sat, q_val;
  logic [PW-1:0] vprod;

  ychc_div #(.NW(NW), .DW(8), .QW(QW)) u_div_hue (
    .clk_i (clk_i), .en_i (en), .num_i (hnum_q), .den_i (d4_q), .quo_o (q_hue)
  );
  ychc_div #(.NW(NW), .DW(8), .QW(QW)) u_div_sat (
    .clk_i (clk_i), .en_i (en), .num_i (snum_q), .den_i (mx4_q), .quo_o (q_sat)
  );

  // value quotient by reciprocal, then delayed to the divider outputs
  assign vprod = PW'(vnum_q) * PW'(VRecip);
  assign q_val = dval_q[QW-1];

  // final stage: hue assembly and window test
  logic [HW-1:0] hue_sum, hue_full;
  logic          hue_ok, sat_ok, val_ok;
  logic [QW-1:0] sat_c;
  logic [HW-1:0] hlo, hhi;
  logic [QW-1:0] slo, shi, vlo, vhi;

  assign hlo = HW'(hue_low_q) << F;
  assign hhi = HW'(hue_high_q) << F;
  assign slo = QW'(sat_low_q) << F;
  assign shi = QW'(sat_high_q) << F;
  assign vlo = QW'(val_low_q) << F;
  assign vhi = QW'(val_high_q) << F;

  always_comb begin
    hue_sum = (HW'(dbase_q[QW-1]) << F) + HW'(q_hue);
    if (dgray_q[QW-1]) hue_full = '0;
    else if (hue_sum > HW'(HueMaxI)) hue_full = HW'(HueMaxI);
    else hue_full = hue_sum;
    sat_c = dgray_q[QW-1] ? '0 : q_sat;
    if (hue_high_q < hue_low_q)
      hue_ok = (hue_full >= hlo && 32'(hue_full) <= HueFullI) || (hue_full <= hhi);
    else
      hue_ok = hue_full >= hlo && hue_full <= hhi;
    sat_ok = sat_c >= slo && sat_c <= shi;
    val_ok = q_val >= vlo && q_val <= vhi;
  end

  logic     vldo_q;
  pix_out_t out_q, skid_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      for (int k = 0; k < QW; k++) dvld_q[k] <= 1'b0;
      vldo_q     <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld0_q <= in_valid_i;
        vld1_q <= vld0_q;
        vld2_q <= vld1_q;
        vld3_q <= vld2_q;
        vld4_q <= vld3_q;
        dvld_q[0] <= vld4_q;
        for (int k = 1; k < QW; k++) dvld_q[k] <= dvld_q[k-1];
        vldo_q <= dvld_q[QW-1];
        // a result not taken this cycle moves aside
        if (vldo_q && !out_ready_i) skid_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      pix0_q <= in_data_i;

      ty_q  <= 28'(K_Y)   * 28'(y_s);
      tr_q  <= 28'(K_RCR) * 28'(cr_s);
      tgb_q <= 28'(K_GCB) * 28'(cb_s);
      tgr_q <= 28'(K_GCR) * 28'(cr_s);
      tb_q  <= 28'(K_BCB) * 28'(cb_s);

      r_q <= clamp8(acc_r);
      g_q <= clamp8(acc_g);
      b_q <= clamp8(acc_b);

      mx_q    <= mx_c;
      d3_q    <= d_c;
      n3_q    <= n_c;
      base3_q <= base_c;
      gray3_q <= (d_c == 8'd0);

      hnum_q  <= (NW'(n3_q) * NW'(60)) << F;
      snum_q  <= (NW'(d3_q) * NW'(100)) << F;
      vnum_q  <= (NW'(mx_q) * NW'(100)) << F;
      d4_q    <= d3_q;
      mx4_q   <= mx_q;
      base4_q <= base3_q;
      gray4_q <= gray3_q;

      dbase_q[0] <= base4_q;
      dgray_q[0] <= gray4_q;
      dval_q[0]  <= QW'(vprod >> VShift);
      for (int k = 1; k < QW; k++) begin
        dbase_q[k] <= dbase_q[k-1];
        dgray_q[k] <= dgray_q[k-1];
        dval_q[k]  <= dval_q[k-1];
      end

      out_q.in_range   <= hue_ok && sat_ok && val_ok;
      out_q.hue        <= 13'(hue_full);
      out_q.saturation <= 11'(sat_c);
      out_q.brightness <= 11'(q_val);

      if (vldo_q && !out_ready_i) skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_vld_q || vldo_q;
  assign out_data_o  = skid_vld_q ? skid_q : out_q;

endmodule

@@ rtl/ychc_div.sv @@
// ----------------------------------------------------------------------------
// ychc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ychc_div #(
  parameter int NW = 19,
  parameter int DW = 8,
  parameter int QW = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);
  localparam int TW = NW + QW + DW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // shifted divisor for quotient bit QW-1-j
    assign trial = TW'(den_in) << (QW - 1 - j);
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? NW'(TW'(rem_in) - trial) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (QW'(take) << (QW - 1 - j));
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

@@ tb/tb_ycbcr_hsv_color_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ycbcr_hsv_color_classifier_unit
// self-checking bench for the ycbcr to hsv color classifier
// ----------------------------------------------------------------------------
// pixels go in through a queue-fed driver with bursty valid, results come
// back through a monitor with its own stall pattern. each accepted pixel is
// run through a local color model and the expected result is queued, then
// compared as a whole with what comes out. the run steps through several
// bound settings, written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_ycbcr_hsv_color_classifier_unit;
  import ychc_pkg::*;

  localparam int FB = HSV_FRACTION_BITS;
  localparam int SC = 1 << FB;
  localparam int LATENCY = FB + 13;
  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // local copy of the bound registers
  logic [8:0] hue_lo, hue_hi;
  logic [6:0] sat_lo, sat_hi, val_lo, val_hi;

  pix_in_t pending_pixels[$];
  pix_out_t expected_hsv[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_sender = 1'b0;
  bit long_stall_req = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;

  // config writes from the initial block, applied at the clock edge
  bit cfg_pending = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_q;
  logic [CFG_DATA_W-1:0] cfg_dat_q;

  ycbcr_hsv_color_classifier_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_ch(longint acc);
    if (acc < 0) return 0;
    acc = acc / 65536;
    return (acc > 255) ? 255 : acc;
  endfunction

  // color model: ycbcr -> rgb -> hsv plus window test
  function automatic pix_out_t classify_pixel(pix_in_t p);
    longint y, cb, cr, r, g, b, mx, mn, d, hue, sat, val, num;
    bit hue_ok, ok;
    pix_out_t o;
    y = longint'(p.luma) - 16;
    cb = longint'(p.blue_diff) - 128;
    cr = longint'(p.red_diff) - 128;
    r = clamp_ch(76309 * y + 104597 * cr + 32768);
    g = clamp_ch(76309 * y - 25664 * cb - 53268 * cr + 32768);
    b = clamp_ch(76309 * y + 132201 * cb + 32768);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0; sat = 0;
    val = (mx * 100 * SC) / 255;
    if (d != 0) begin
      sat = (d * 100 * SC) / mx;
      // red wins ties, then green
      if (r == mx) begin
        num = 60 * SC * (g - b);
        if (g < b) num += 360 * SC * d;
      end else if (g == mx) begin
        num = 120 * SC * d + 60 * SC * (b - r);
      end else begin
        num = 240 * SC * d + 60 * SC * (r - g);
      end
      hue = num / d;
      if (hue > 360 * SC - 1) hue = 360 * SC - 1;
    end
    // wrapped window when the upper bound sits below the lower one
    if (hue_hi < hue_lo)
      hue_ok = (hue >= longint'(hue_lo) * SC && hue <= 360 * SC) ||
               (hue <= longint'(hue_hi) * SC);
    else
      hue_ok = hue >= longint'(hue_lo) * SC && hue <= longint'(hue_hi) * SC;
    ok = hue_ok && sat >= longint'(sat_lo) * SC && sat <= longint'(sat_hi) * SC &&
         val >= longint'(val_lo) * SC && val <= longint'(val_hi) * SC;
    o.in_range = ok;
    o.hue = hue[12:0];
    o.saturation = sat[10:0];
    o.brightness = val[10:0];
    return o;
  endfunction

  // driver: bursts of valid with random gaps
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    cfg_we_i <= cfg_pending;
    cfg_index_i <= cfg_idx_q;
    cfg_data_i <= cfg_dat_q;
    cfg_pending <= 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_hsv.push_back(classify_pixel(in_data_i));
        void'(pending_pixels.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the pixel until taken
      end else if (hold_sender) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        // an accepted head is already gone from pending_pixels here
        if (pending_pixels.size() != 0) begin
          in_data_i <= pending_pixels[0];
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare against the oldest expected result
  always @(posedge clk_i) begin
    pix_out_t exp_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hsv.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data_o);
        end else begin
          exp_o = expected_hsv.pop_front();
          if (exp_o !== out_data_o) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp rng=%0d h=%0d s=%0d v=%0d got rng=%0d h=%0d s=%0d v=%0d",
                       exp_o.in_range, exp_o.hue, exp_o.saturation, exp_o.brightness,
                       out_data_o.in_range, out_data_o.hue, out_data_o.saturation,
                       out_data_o.brightness);
          end
        end
      end
      // receiver stall pattern, with one long hold-off on request
      if (long_stall_req && stall_left == 0) begin
        stall_left <= 300;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= (stall_left == 1);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: out_ready_i <= 1'b0;
          2: begin
            stall_left <= $urandom_range(2, 12);
            out_ready_i <= 1'b0;
          end
          default: out_ready_i <= 1'b1;
        endcase
      end
    end
    if (cycles > LIMIT) begin
      $display("ycbcr_hsv_color_classifier_unit verification failed");
      $finish;
    end
  end

  task automatic write_bound(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_idx_q = idx;
    cfg_dat_q = value[CFG_DATA_W-1:0];
    cfg_pending = 1'b1;
    case (idx)
      CFG_HUE_LOW: hue_lo = value[8:0];
      CFG_HUE_HIGH: hue_hi = value[8:0];
      CFG_SAT_LOW: sat_lo = value[6:0];
      CFG_SAT_HIGH: sat_hi = value[6:0];
      CFG_VAL_LOW: val_lo = value[6:0];
      CFG_VAL_HIGH: val_hi = value[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_window(int hl, int hh, int sl, int sh, int vl, int vh);
    write_bound(CFG_HUE_LOW, hl);
    write_bound(CFG_HUE_HIGH, hh);
    write_bound(CFG_SAT_LOW, sl);
    write_bound(CFG_SAT_HIGH, sh);
    write_bound(CFG_VAL_LOW, vl);
    write_bound(CFG_VAL_HIGH, vh);
  endtask

  // wait until the pipeline is drained
  task automatic drain_pipe();
    while (pending_pixels.size() != 0 || in_valid_i || expected_hsv.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic queue_pixel(int y, int cb, int cr);
    pix_in_t p;
    p.luma = y[7:0];
    p.blue_diff = cb[7:0];
    p.red_diff = cr[7:0];
    pending_pixels.push_back(p);
  endtask

  // mostly random pixels, some near gray and some at the range edges
  task automatic queue_random(int n);
    int k, y, sel;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      y = $urandom_range(0, 255);
      if (sel == 0) queue_pixel(y, 128, 128);
      else if (sel == 1) queue_pixel(y, 128 + $urandom_range(0, 2) - 1,
                                     128 + $urandom_range(0, 2) - 1);
      else if (sel == 2) queue_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                                     $urandom_range(0, 1) * 255);
      else queue_pixel(y, $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int ph;
    hue_lo = HUE_LOW_RST; hue_hi = HUE_HIGH_RST;
    sat_lo = SAT_LOW_RST; sat_hi = SAT_HIGH_RST;
    val_lo = VAL_LOW_RST; val_hi = VAL_HIGH_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels under the reset bounds
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(16, 128, 128);       // black
    queue_pixel(235, 128, 128);      // white
    queue_pixel(126, 128, 128);      // mid gray
    queue_pixel(81, 90, 240);        // red
    queue_pixel(145, 54, 34);        // green
    queue_pixel(41, 240, 110);       // blue
    queue_pixel(210, 16, 146);       // yellow
    queue_pixel(170, 166, 16);       // cyan
    queue_pixel(106, 202, 222);      // magenta
    queue_pixel(82, 200, 60);        // blueish, blue-sector hue with red clamped to zero
    queue_pixel(100, 160, 200);
    queue_pixel(60, 140, 170);
    queue_pixel(128, 0, 255);
    queue_pixel(128, 255, 0);
    queue_pixel(200, 120, 180);
    queue_pixel(30, 200, 140);
    queue_random(6);
    drain_pipe();

    // long receiver hold-off while the sender keeps offering
    queue_random(150);
    long_stall_req = 1'b1;
    while (stall_left < 200) @(posedge clk_i);
    long_stall_req = 1'b0;
    drain_pipe();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_window(0, 360, 0, 100, 0, 100);
        1: set_window(300, 60, 10, 90, 5, 95);     // wrapped hue window
        2: set_window(360, 0, 100, 0, 100, 0);     // wrapped, extremes
        3: set_window(511, 511, 127, 127, 127, 127);
        4: set_window(0, 0, 0, 0, 0, 0);
        default: set_window($urandom_range(0, 360), $urandom_range(0, 360),
                             $urandom_range(0, 100), $urandom_range(0, 100),
                             $urandom_range(0, 100), $urandom_range(0, 100));
      endcase
      queue_random(200);
      // sender pause until everything has come back
      while (pending_pixels.size() > 100) @(posedge clk_i);
      hold_sender = 1'b1;
      while (in_valid_i || expected_hsv.size() != 0) @(posedge clk_i);
      hold_sender = 1'b0;
      drain_pipe();
    end

    if (mismatches == 0)
      $display("ycbcr_hsv_color_classifier_unit verification clean");
    else
      $display("ycbcr_hsv_color_classifier_unit verification failed");
    $finish;
  end

endmodule
